[rtl/mept_pkg.sv]
// Shared constants and types for the mesh edge pairing table.
package mept_pkg;

    // Default sizing of the edge table
    localparam int MAX_EDGES_DEF    = 1024;
    localparam int VERTEX_BITS_DEF  = 16;
    localparam int POLYGON_BITS_DEF = 16;

    // Fixed field widths on the channels
    localparam int VERTEX_W  = 16;
    localparam int POLYGON_W = 16;
    localparam int SIDE_W    = 4;
    localparam int INDEX_W   = 10;
    localparam int COUNT_W   = 11;
    localparam int STATUS_W  = 3;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_SAME_DIR = 3'd1,
        ST_REPEAT   = 3'd2,
        ST_THIRD    = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

endpackage

[rtl/mept_side_if.sv]
// Input channel: one directed polygon side per word.
interface mept_side_if;
    logic                          valid;
    logic                          ready;
    logic [mept_pkg::VERTEX_W-1:0]  vertex_from;
    logic [mept_pkg::VERTEX_W-1:0]  vertex_to;
    logic [mept_pkg::POLYGON_W-1:0] polygon_id;
    logic [mept_pkg::SIDE_W-1:0]    side_id;
    logic                          new_mesh;

    modport source (output valid, output vertex_from, output vertex_to,
                    output polygon_id, output side_id, output new_mesh,
                    input ready);
    modport sink   (input valid, input vertex_from, input vertex_to,
                    input polygon_id, input side_id, input new_mesh,
                    output ready);
endinterface

[rtl/mept_result_if.sv]
// Output channel: one pairing result per word.
interface mept_result_if;
    logic                          valid;
    logic                          ready;
    logic [mept_pkg::INDEX_W-1:0]  edge_index;
    logic                          direction;
    logic [mept_pkg::STATUS_W-1:0] status;
    logic                          closed;
    logic [mept_pkg::COUNT_W-1:0]  edge_count;

    modport source (output valid, output edge_index, output direction,
                    output status, output closed, output edge_count,
                    input ready);
    modport sink   (input valid, input edge_index, input direction,
                    input status, input closed, input edge_count,
                    output ready);
endinterface

[rtl/mept_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mept_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/mesh_edge_pairing_table.sv]
// Half-edge twin pairing table: top level with scan sequencer and edge RAM.
//
// Usage: each word on 'sides' is one directed polygon side. The block scans
// the stored edges in insertion order, one entry per cycle, through a single
// compare unit fed by the read port of the edge RAM. The first entry that
// matches decides: the same direction gives an orientation error, and a
// reverse entry is paired (or reported as a repeated or third polygon).
// With no match the side is appended, or the full status is returned.
// new_mesh empties the table before the side is handled.
// Sequence: after a side is accepted, the scan makes up to one RAM read per
// stored edge, then the last compare and the decision, and the output
// register is loaded; with an empty table the scan goes straight to the
// decision. The block takes one side at a time: 'sides.ready' is high
// only while the sequencer is idle, and the next side can be taken while
// the previous result still waits.
// Stall: a result held by a low 'results.ready' stays in the output register;
// a following side is scanned and then waits until that register frees.
// Reset: the table becomes empty; no clearing pass over the RAM is needed,
// since only entries below the edge count are ever compared.
module mesh_edge_pairing_table #(
    parameter int MAX_EDGES    = mept_pkg::MAX_EDGES_DEF,
    parameter int VERTEX_BITS  = mept_pkg::VERTEX_BITS_DEF,
    parameter int POLYGON_BITS = mept_pkg::POLYGON_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    mept_side_if.sink     sides,
    mept_result_if.source results
);

    localparam int IDX_W = $clog2(MAX_EDGES);
    localparam int CNT_W = $clog2(MAX_EDGES + 1);

    // One table entry
    typedef struct packed {
        logic [VERTEX_BITS-1:0]      start_v;
        logic [VERTEX_BITS-1:0]      end_v;
        logic [POLYGON_BITS-1:0]     first_poly;
        logic [mept_pkg::SIDE_W-1:0] first_side;
        logic [POLYGON_BITS-1:0]     second_poly;
        logic [mept_pkg::SIDE_W-1:0] second_side;
        logic                        shared;
    } entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t                      state_reg, state_next;
    logic [VERTEX_BITS-1:0]      a_reg, a_next;
    logic [VERTEX_BITS-1:0]      b_reg, b_next;
    logic [POLYGON_BITS-1:0]     poly_reg, poly_next;
    logic [mept_pkg::SIDE_W-1:0] side_reg, side_next;
    logic [CNT_W-1:0]            ptr_reg, ptr_next;
    logic                        chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]            chk_idx_reg, chk_idx_next;
    logic [CNT_W-1:0]            stored_reg, stored_next;
    logic [CNT_W-1:0]            unpaired_reg, unpaired_next;
    logic [IDX_W-1:0]            res_idx_reg, res_idx_next;
    logic                        res_dir_reg, res_dir_next;
    mept_pkg::status_t           res_status_reg, res_status_next;

    logic                           out_valid_reg, out_valid_next;
    logic [mept_pkg::INDEX_W-1:0]   out_index_reg, out_index_next;
    logic                           out_dir_reg, out_dir_next;
    mept_pkg::status_t              out_status_reg, out_status_next;
    logic                           out_closed_reg, out_closed_next;
    logic [mept_pkg::COUNT_W-1:0]   out_count_reg, out_count_next;

    // RAM port signals
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    entry_t           rd_entry;

    // Input fields taken to stored widths
    logic [31:0] from_wide, to_wide, poly_wide;
    logic [31:0] idx_wide, cnt_wide;

    // Shared compare unit
    logic same_dir, rev_dir;

    mept_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_entry)
    );

    assign from_wide = 32'(sides.vertex_from);
    assign to_wide   = 32'(sides.vertex_to);
    assign poly_wide = 32'(sides.polygon_id);
    assign idx_wide  = 32'(res_idx_reg);
    assign cnt_wide  = 32'(stored_reg);

    assign same_dir = (rd_entry.start_v == a_reg) && (rd_entry.end_v == b_reg);
    assign rev_dir  = (rd_entry.start_v == b_reg) && (rd_entry.end_v == a_reg);

    assign sides.ready        = (state_reg == S_IDLE);
    assign results.valid      = out_valid_reg;
    assign results.edge_index = out_index_reg;
    assign results.direction  = out_dir_reg;
    assign results.status     = out_status_reg;
    assign results.closed     = out_closed_reg;
    assign results.edge_count = out_count_reg;

    // Sequencer next-state logic
    always_comb
    begin
        state_next      = state_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        poly_next       = poly_reg;
        side_next       = side_reg;
        ptr_next        = ptr_reg;
        chk_valid_next  = chk_valid_reg;
        chk_idx_next    = chk_idx_reg;
        stored_next     = stored_reg;
        unpaired_next   = unpaired_reg;
        res_idx_next    = res_idx_reg;
        res_dir_next    = res_dir_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_index_next  = out_index_reg;
        out_dir_next    = out_dir_reg;
        out_status_next = out_status_reg;
        out_closed_next = out_closed_reg;
        out_count_next  = out_count_reg;
        ram_we          = 1'b0;
        ram_waddr       = chk_idx_reg;
        ram_wdata       = rd_entry;
        ram_raddr       = ptr_reg[IDX_W-1:0];

        // Output word taken
        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (sides.valid)
                begin
                    a_next         = from_wide[VERTEX_BITS-1:0];
                    b_next         = to_wide[VERTEX_BITS-1:0];
                    poly_next      = poly_wide[POLYGON_BITS-1:0];
                    side_next      = sides.side_id;
                    ptr_next       = '0;
                    chk_valid_next = 1'b0;
                    if (sides.new_mesh)
                    begin
                        stored_next   = '0;
                        unpaired_next = '0;
                    end
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (chk_valid_reg && (same_dir || rev_dir))
                begin
                    // First match decides the outcome
                    chk_valid_next  = 1'b0;
                    res_idx_next    = chk_idx_reg;
                    res_dir_next    = 1'b0;
                    state_next      = S_DONE;
                    if (same_dir)
                    begin
                        res_status_next = mept_pkg::ST_SAME_DIR;
                    end
                    else if (rd_entry.first_poly == poly_reg)
                    begin
                        res_status_next = mept_pkg::ST_REPEAT;
                    end
                    else if (rd_entry.shared)
                    begin
                        res_status_next = mept_pkg::ST_THIRD;
                    end
                    else
                    begin
                        // Pair as second owner
                        ram_we                = 1'b1;
                        ram_waddr             = chk_idx_reg;
                        ram_wdata             = rd_entry;
                        ram_wdata.second_poly = poly_reg;
                        ram_wdata.second_side = side_reg;
                        ram_wdata.shared      = 1'b1;
                        if (unpaired_reg != '0)
                        begin
                            unpaired_next = unpaired_reg - CNT_W'(1);
                        end
                        res_dir_next    = 1'b1;
                        res_status_next = mept_pkg::ST_OK;
                    end
                end
                else if (ptr_reg < stored_reg)
                begin
                    // Fetch next stored entry
                    ram_raddr      = ptr_reg[IDX_W-1:0];
                    chk_valid_next = 1'b1;
                    chk_idx_next   = ptr_reg[IDX_W-1:0];
                    ptr_next       = ptr_reg + CNT_W'(1);
                end
                else if (chk_valid_reg)
                begin
                    // Last entry compared without a match
                    chk_valid_next = 1'b0;
                end
                else
                begin
                    // No match: append or flag a full table
                    res_dir_next = 1'b0;
                    state_next   = S_DONE;
                    if (stored_reg == CNT_W'(MAX_EDGES))
                    begin
                        res_idx_next    = '0;
                        res_status_next = mept_pkg::ST_FULL;
                    end
                    else
                    begin
                        ram_we                = 1'b1;
                        ram_waddr             = stored_reg[IDX_W-1:0];
                        ram_wdata.start_v     = a_reg;
                        ram_wdata.end_v       = b_reg;
                        ram_wdata.first_poly  = poly_reg;
                        ram_wdata.first_side  = side_reg;
                        ram_wdata.second_poly = '0;
                        ram_wdata.second_side = '0;
                        ram_wdata.shared      = 1'b0;
                        res_idx_next          = stored_reg[IDX_W-1:0];
                        res_status_next       = mept_pkg::ST_OK;
                        stored_next           = stored_reg + CNT_W'(1);
                        unpaired_next         = unpaired_reg + CNT_W'(1);
                    end
                end
            end

            S_DONE:
            begin
                // Load the output register once it is free
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_index_next  = idx_wide[mept_pkg::INDEX_W-1:0];
                    out_dir_next    = res_dir_reg;
                    out_status_next = res_status_reg;
                    out_closed_next = (unpaired_reg == '0);
                    out_count_next  = cnt_wide[mept_pkg::COUNT_W-1:0];
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            a_reg          <= '0;
            b_reg          <= '0;
            poly_reg       <= '0;
            side_reg       <= '0;
            ptr_reg        <= '0;
            chk_valid_reg  <= 1'b0;
            chk_idx_reg    <= '0;
            stored_reg     <= '0;
            unpaired_reg   <= '0;
            res_idx_reg    <= '0;
            res_dir_reg    <= 1'b0;
            res_status_reg <= mept_pkg::ST_OK;
            out_valid_reg  <= 1'b0;
            out_index_reg  <= '0;
            out_dir_reg    <= 1'b0;
            out_status_reg <= mept_pkg::ST_OK;
            out_closed_reg <= 1'b0;
            out_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            a_reg          <= a_next;
            b_reg          <= b_next;
            poly_reg       <= poly_next;
            side_reg       <= side_next;
            ptr_reg        <= ptr_next;
            chk_valid_reg  <= chk_valid_next;
            chk_idx_reg    <= chk_idx_next;
            stored_reg     <= stored_next;
            unpaired_reg   <= unpaired_next;
            res_idx_reg    <= res_idx_next;
            res_dir_reg    <= res_dir_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_index_reg  <= out_index_next;
            out_dir_reg    <= out_dir_next;
            out_status_reg <= out_status_next;
            out_closed_reg <= out_closed_next;
            out_count_reg  <= out_count_next;
        end
    end

endmodule

[rtl/mept_checker.sv]
// Port-level assertions for the edge pairing table, bound to the top level.
module mept_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [mept_pkg::INDEX_W-1:0]  edge_index,
    input logic                          direction,
    input logic [mept_pkg::STATUS_W-1:0] status,
    input logic [mept_pkg::COUNT_W-1:0]  edge_count
);

    // A stalled result word holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(edge_index) &&
        $stable(direction) && $stable(status) && $stable(edge_count))
        else $error("stalled result word changed");

    // One side at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("side accepted while another is in work");

    // Error results never carry the reverse direction
    a_err_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != mept_pkg::ST_OK) |-> !direction)
        else $error("error result with direction set");

    // A newly created edge is the last one in the table
    a_append_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == mept_pkg::ST_OK) && !direction |->
        edge_index == mept_pkg::INDEX_W'(edge_count - mept_pkg::COUNT_W'(1)))
        else $error("appended edge index does not match edge count");

endmodule

bind mesh_edge_pairing_table mept_checker u_mept_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sides.valid),
    .in_ready   (sides.ready),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .edge_index (results.edge_index),
    .direction  (results.direction),
    .status     (results.status),
    .edge_count (results.edge_count)
);

[dv/tb_top.sv]
// Self-checking testbench for the mesh edge pairing table.
module tb_top;

    localparam int TABLE_DEPTH  = mept_pkg::MAX_EDGES_DEF;
    localparam int RANDOM_SIDES = 500;
    localparam int QUIET_LIMIT  = 6000;

    // One side word and one result word as the predictor sees them
    typedef struct {
        logic [mept_pkg::VERTEX_W-1:0]  v_from;
        logic [mept_pkg::VERTEX_W-1:0]  v_to;
        logic [mept_pkg::POLYGON_W-1:0] poly;
        logic [mept_pkg::SIDE_W-1:0]    side;
        logic                           fresh;
    } side_word_t;

    typedef struct {
        logic [mept_pkg::INDEX_W-1:0] idx;
        logic                         dir;
        mept_pkg::status_t            status;
        logic                         closed;
        logic [mept_pkg::COUNT_W-1:0] count;
    } result_word_t;

    typedef struct {
        side_word_t   w;
        bit           typed;
        result_word_t r;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    mept_side_if   side_ch ();
    mept_result_if res_ch ();

    mesh_edge_pairing_table DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .sides   (side_ch),
        .results (res_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Predictor copy of the edge table
    logic [mept_pkg::VERTEX_W-1:0]  tbl_from   [TABLE_DEPTH];
    logic [mept_pkg::VERTEX_W-1:0]  tbl_to     [TABLE_DEPTH];
    logic [mept_pkg::POLYGON_W-1:0] tbl_owner  [TABLE_DEPTH];
    logic                           tbl_shared [TABLE_DEPTH];
    int                             n_edges = 0;
    int                             n_open  = 0;

    stim_row_t    side_plan [$];
    result_word_t pending_results [$];

    int n_errors     = 0;
    int n_sent       = 0;
    int n_checked    = 0;
    int quiet_cycles = 0;
    int status_seen [5] = '{default: 0};
    bit steady;

    // Stretch of the run with no idling on either side
    assign steady = (n_sent >= 200) && (n_sent < 320);

    // Expected result of one side; updates the table copy
    function automatic result_word_t pair_side(side_word_t w);
        result_word_t r;
        bit           hit;
        int           i;
        r.idx    = '0;
        r.dir    = 1'b0;
        r.status = mept_pkg::ST_OK;
        hit      = 1'b0;
        if (w.fresh)
        begin
            n_edges = 0;
            n_open  = 0;
        end
        for (i = 0; i < n_edges && !hit; i++)
        begin
            if (tbl_from[i] == w.v_from && tbl_to[i] == w.v_to)
            begin
                hit      = 1'b1;
                r.idx    = i[mept_pkg::INDEX_W-1:0];
                r.status = mept_pkg::ST_SAME_DIR;
            end
            else if (tbl_from[i] == w.v_to && tbl_to[i] == w.v_from)
            begin
                hit   = 1'b1;
                r.idx = i[mept_pkg::INDEX_W-1:0];
                if (tbl_owner[i] == w.poly)
                    r.status = mept_pkg::ST_REPEAT;
                else if (tbl_shared[i])
                    r.status = mept_pkg::ST_THIRD;
                else
                begin
                    tbl_shared[i] = 1'b1;
                    if (n_open > 0)
                        n_open--;
                    r.dir = 1'b1;
                end
            end
        end
        if (!hit)
        begin
            if (n_edges >= TABLE_DEPTH)
                r.status = mept_pkg::ST_FULL;
            else
            begin
                r.idx               = n_edges[mept_pkg::INDEX_W-1:0];
                tbl_from[n_edges]   = w.v_from;
                tbl_to[n_edges]     = w.v_to;
                tbl_owner[n_edges]  = w.poly;
                tbl_shared[n_edges] = 1'b0;
                n_edges++;
                n_open++;
            end
        end
        r.closed = (n_open == 0);
        r.count  = n_edges[mept_pkg::COUNT_W-1:0];
        return r;
    endfunction

    function automatic int field_bad(string name, int unsigned exp_v, int unsigned got_v);
        if (exp_v == got_v)
            return 0;
        $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, got_v);
        return 1;
    endfunction

    task automatic add_side(input logic [15:0] a, input logic [15:0] b,
                            input logic [15:0] poly, input logic [3:0] side,
                            input logic fresh);
        stim_row_t row;
        row.w     = '{a, b, poly, side, fresh};
        row.typed = 1'b0;
        row.r     = '{'0, 1'b0, mept_pkg::ST_OK, 1'b0, '0};
        side_plan.push_back(row);
    endtask

    task automatic add_checked(input logic [15:0] a, input logic [15:0] b,
                               input logic [15:0] poly, input logic [3:0] side,
                               input logic fresh, input int idx, input int dir,
                               input mept_pkg::status_t st, input int closed,
                               input int count);
        stim_row_t row;
        row.w     = '{a, b, poly, side, fresh};
        row.typed = 1'b1;
        row.r     = '{idx[mept_pkg::INDEX_W-1:0], dir[0], st, closed[0],
                      count[mept_pkg::COUNT_W-1:0]};
        side_plan.push_back(row);
    endtask

    // Directed table: extremes, every status but full, degenerate side
    task automatic build_directed();
        //          from      to        poly      side  new   idx dir status  cl  cnt
        add_checked(16'h0000, 16'hFFFF, 16'h0000, 4'h0, 1'b0, 0,  0,
                    mept_pkg::ST_OK,       0,  1);
        add_checked(16'hFFFF, 16'h0000, 16'hFFFF, 4'hF, 1'b0, 0,  1,
                    mept_pkg::ST_OK,       1,  1);
        add_checked(16'h0000, 16'hFFFF, 16'h0005, 4'h3, 1'b0, 0,  0,
                    mept_pkg::ST_SAME_DIR, 1,  1);
        add_checked(16'hFFFF, 16'h0000, 16'h0007, 4'h1, 1'b0, 0,  0,
                    mept_pkg::ST_THIRD,    1,  1);
        add_checked(16'h1234, 16'h1234, 16'h0009, 4'h2, 1'b0, 1,  0,
                    mept_pkg::ST_OK,       0,  2);
        add_checked(16'h1234, 16'h1234, 16'h000A, 4'h2, 1'b0, 1,  0,
                    mept_pkg::ST_SAME_DIR, 0,  2);
        add_checked(16'h00FF, 16'hFF00, 16'h0003, 4'h4, 1'b0, 2,  0,
                    mept_pkg::ST_OK,       0,  3);
        add_checked(16'hFF00, 16'h00FF, 16'h0003, 4'h5, 1'b0, 2,  0,
                    mept_pkg::ST_REPEAT,   0,  3);
        add_checked(16'hAAAA, 16'h5555, 16'h8000, 4'h8, 1'b1, 0,  0,
                    mept_pkg::ST_OK,       0,  1);
        add_checked(16'h5555, 16'hAAAA, 16'h0001, 4'hA, 1'b0, 0,  1,
                    mept_pkg::ST_OK,       1,  1);
        // triangle pillow: two faces over the same loop
        add_side(16'h0001, 16'h0002, 16'h0002, 4'h0, 1'b1);
        add_side(16'h0002, 16'h0003, 16'h0002, 4'h1, 1'b0);
        add_side(16'h0003, 16'h0001, 16'h0002, 4'h2, 1'b0);
        add_side(16'h0002, 16'h0001, 16'h0004, 4'h0, 1'b0);
        add_side(16'h0001, 16'h0003, 16'h0004, 4'h1, 1'b0);
        add_side(16'h0003, 16'h0002, 16'h0004, 4'h2, 1'b0);
        add_side(16'h0003, 16'h0002, 16'h0006, 4'h7, 1'b0);
    endtask

    // Random part: mostly closed meshes with random labels, some broken ones and noise
    task automatic build_random();
        int            faces [12] = '{0, 2, 1, 0, 1, 3, 1, 2, 3, 0, 3, 2};
        logic [15:0]   vtx [8];
        logic [15:0]   pa, pb, pc;
        logic          fresh;
        int            kind, m, j, start;
        start = side_plan.size();
        while (side_plan.size() - start < RANDOM_SIDES)
        begin
            kind  = $urandom_range(99);
            fresh = ($urandom_range(3) != 0);
            for (j = 0; j < 8; j++)
                vtx[j] = 16'($urandom_range(65535));
            pa = 16'($urandom_range(65535));
            pb = 16'($urandom_range(65535));
            pc = 16'($urandom_range(65535));
            if (kind < 40)
            begin
                // pillow: one loop, then the same loop reversed
                m = $urandom_range(3, 8);
                for (j = 0; j < m; j++)
                    add_side(vtx[j], vtx[(j + 1) % m], pa, 4'(j), fresh && j == 0);
                for (j = m - 1; j >= 0; j--)
                    add_side(vtx[(j + 1) % m], vtx[j], pb, 4'($urandom_range(15)), 1'b0);
            end
            else if (kind < 65)
            begin
                // tetrahedron with consistent orientation
                for (j = 0; j < 12; j++)
                    add_side(vtx[faces[j]], vtx[faces[(j / 3) * 3 + (j + 1) % 3]],
                             (j < 6) ? ((j < 3) ? pa : pb) : ((j < 9) ? pc : ~pa),
                             4'(j % 3), fresh && j == 0);
            end
            else if (kind < 85)
            begin
                // broken mesh: orientation error, repeat, pairing, third owner, degenerate
                add_side(vtx[0], vtx[1], pa, 4'd0, fresh);
                add_side(vtx[1], vtx[2], pa, 4'd1, 1'b0);
                add_side(vtx[2], vtx[0], pa, 4'd2, 1'b0);
                add_side(vtx[0], vtx[1], pb, 4'($urandom_range(15)), 1'b0);
                add_side(vtx[1], vtx[0], pa, 4'($urandom_range(15)), 1'b0);
                add_side(vtx[2], vtx[1], pb, 4'($urandom_range(15)), 1'b0);
                add_side(vtx[2], vtx[1], pc, 4'($urandom_range(15)), 1'b0);
                add_side(vtx[0], vtx[0], pc, 4'($urandom_range(15)), 1'b0);
                add_side(vtx[0], vtx[0], pb, 4'($urandom_range(15)), 1'b0);
            end
            else
            begin
                // noise over a tiny vertex pool or fully random
                m = $urandom_range(1, 6);
                for (j = 0; j < m; j++)
                begin
                    if ($urandom_range(1))
                        add_side(vtx[3'($urandom_range(2))], vtx[3'($urandom_range(2))],
                                 16'($urandom_range(3)), 4'($urandom_range(15)),
                                 $urandom_range(7) == 0);
                    else
                        add_side(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                                 16'($urandom_range(65535)), 4'($urandom_range(15)),
                                 $urandom_range(7) == 0);
                end
            end
        end
    endtask

    // Fill the table to the top, then probe it while full
    task automatic build_full_table();
        int k;
        for (k = 0; k < TABLE_DEPTH; k++)
            add_side(16'(k), 16'(k + 32'h8000), 16'(k), 4'(k % 16), k == 0);
        add_side(16'h7FFF, 16'hFFFF, 16'h1111, 4'h1, 1'b0);
        add_side(16'h83FF, 16'h03FF, 16'h5000, 4'h2, 1'b0);
        add_side(16'h0005, 16'h8005, 16'h2222, 4'h3, 1'b0);
        add_side(16'hFFFF, 16'h0000, 16'h3333, 4'h4, 1'b0);
        add_side(16'h83FF, 16'h03FF, 16'h6000, 4'h5, 1'b0);
        add_side(16'h83FF, 16'h03FF, 16'h03FF, 4'h6, 1'b0);
        add_side(16'h0010, 16'h0020, 16'h0001, 4'h0, 1'b1);
    endtask

    // Reset and input defaults
    initial
    begin
        rst_n               = 1'b0;
        side_ch.valid       = 1'b0;
        side_ch.vertex_from = '0;
        side_ch.vertex_to   = '0;
        side_ch.polygon_id  = '0;
        side_ch.side_id     = '0;
        side_ch.new_mesh    = 1'b0;
        res_ch.ready        = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Side driver: presents each planned word and predicts it on acceptance
    initial
    begin
        stim_row_t    row;
        result_word_t p;
        build_directed();
        build_random();
        build_full_table();
        @(posedge rst_n);
        @(posedge clk);
        while (side_plan.size() > 0)
        begin
            if (!steady && $urandom_range(99) < 28)
            begin
                side_ch.valid <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                row = side_plan.pop_front();
                side_ch.valid       <= 1'b1;
                side_ch.vertex_from <= row.w.v_from;
                side_ch.vertex_to   <= row.w.v_to;
                side_ch.polygon_id  <= row.w.poly;
                side_ch.side_id     <= row.w.side;
                side_ch.new_mesh    <= row.w.fresh;
                @(posedge clk);
                while (!side_ch.ready)
                    @(posedge clk);
                p = pair_side(row.w);
                status_seen[p.status]++;
                pending_results.push_back(row.typed ? row.r : p);
                n_sent++;
            end
        end
        side_ch.valid <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        // any stray word would show up within one full scan
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        $display("sent %0d sides, checked %0d results, filled the table to %0d edges",
                 n_sent, n_checked, TABLE_DEPTH);
        $display("statuses: ok %0d, same-dir %0d, repeat %0d, third %0d, full %0d",
                 status_seen[mept_pkg::ST_OK], status_seen[mept_pkg::ST_SAME_DIR],
                 status_seen[mept_pkg::ST_REPEAT], status_seen[mept_pkg::ST_THIRD],
                 status_seen[mept_pkg::ST_FULL]);
        if (n_errors == 0)
            $display("mesh_edge_pairing_table: match");
        else
            $display("mesh_edge_pairing_table: mismatch");
        $finish;
    end

    // Result checker and back-pressure
    always @(posedge clk)
    begin
        result_word_t e;
        if (rst_n)
        begin
            if ((side_ch.valid && side_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (res_ch.valid && res_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result word with none expected, actual index %0d status %0d",
                             $time, res_ch.edge_index, res_ch.status);
                    n_errors++;
                end
                else
                begin
                    e = pending_results.pop_front();
                    n_errors += field_bad("edge_index", 32'(e.idx), 32'(res_ch.edge_index));
                    n_errors += field_bad("direction", 32'(e.dir), 32'(res_ch.direction));
                    n_errors += field_bad("status", 32'(e.status), 32'(res_ch.status));
                    n_errors += field_bad("closed", 32'(e.closed), 32'(res_ch.closed));
                    n_errors += field_bad("edge_count", 32'(e.count), 32'(res_ch.edge_count));
                    n_checked++;
                end
            end
            res_ch.ready <= steady || ($urandom_range(99) >= 28);
        end
    end

    // Watchdog on cycles with no word moving
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("mesh_edge_pairing_table: mismatch");
        $finish;
    end

endmodule
